// ===== hdl/edg_pkg.sv =====
// shared types, constants and gamma table of the encoder dimmer
package edg_pkg;

  localparam int unsigned LevelW    = 5;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned MsW       = 8;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [LevelW-1:0] LevelMax      = 5'd23;
  localparam logic [LevelW-1:0] LevelReset    = 5'd10;
  localparam logic [MsW-1:0]    DebounceReset = 8'd50;
  localparam logic [MsW-1:0]    ElapsedMax    = 8'd255;

  typedef enum logic [0:0] {
    RegDebounceMs = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic button_n;
    logic enc_a;
    logic enc_b;
    logic ms_tick;
  } smp_t;

  typedef struct packed {
    logic [DutyW-1:0]  pwm_duty;
    logic              light_on;
    logic [LevelW-1:0] level;
  } res_t;

  function automatic logic [DutyW-1:0] gamma_lut(input logic [LevelW-1:0] idx);
    logic [DutyW-1:0] duty;
    case (idx)
      5'd0:    duty = 8'd2;
      5'd1:    duty = 8'd4;
      5'd2:    duty = 8'd7;
      5'd3:    duty = 8'd10;
      5'd4:    duty = 8'd13;
      5'd5:    duty = 8'd17;
      5'd6:    duty = 8'd22;
      5'd7:    duty = 8'd27;
      5'd8:    duty = 8'd33;
      5'd9:    duty = 8'd39;
      5'd10:   duty = 8'd47;
      5'd11:   duty = 8'd55;
      5'd12:   duty = 8'd64;
      5'd13:   duty = 8'd74;
      5'd14:   duty = 8'd85;
      5'd15:   duty = 8'd97;
      5'd16:   duty = 8'd110;
      5'd17:   duty = 8'd124;
      5'd18:   duty = 8'd140;
      5'd19:   duty = 8'd158;
      5'd20:   duty = 8'd176;
      5'd21:   duty = 8'd196;
      5'd22:   duty = 8'd218;
      default: duty = 8'd255;
    endcase
    return duty;
  endfunction

endpackage

// ===== hdl/edg_smp_if.sv =====
// sample channel: button, encoder phases and millisecond strobe
interface edg_smp_if;
  logic valid;
  logic ready;
  logic button_n;
  logic enc_a;
  logic enc_b;
  logic ms_tick;

  modport source (output valid, output button_n, output enc_a, output enc_b,
                  output ms_tick, input ready);
  modport sink (input valid, input button_n, input enc_a, input enc_b,
                input ms_tick, output ready);
endinterface

// ===== hdl/edg_res_if.sv =====
// result channel: duty, light state and level
interface edg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_duty;
  logic       light_on;
  logic [4:0] level;

  modport source (output valid, output pwm_duty, output light_on, output level,
                  input ready);
  modport sink (input valid, input pwm_duty, input light_on, input level,
                output ready);
endinterface

// ===== hdl/edg_core.sv =====
// dimmer state: debounce, encoder stepping and gamma lookup
module edg_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  edg_pkg::smp_t              smp_i,
  input  logic [edg_pkg::MsW-1:0]    debounce_ms_i,
  output edg_pkg::res_t              res_o
);

  logic                         on_q, on_d;
  logic [edg_pkg::LevelW-1:0]   level_q, level_d;
  logic                         acc_q, acc_d;
  logic [edg_pkg::MsW-1:0]      elapsed_q, elapsed_d;
  logic                         a_armed_q, a_armed_d;
  logic                         b_armed_q, b_armed_d;
  logic                         b_seen_q, b_seen_d;
  logic                         prev_a_q, prev_a_d;

  logic [edg_pkg::MsW-1:0]      elapsed_t;
  logic                         pressed;
  logic                         btn_take;
  logic                         a_fall;
  logic [edg_pkg::LevelW-1:0]   level_a;
  logic                         a_armed_a;
  logic                         b_armed_a;

  assign pressed = ~smp_i.button_n;

  always_comb begin
    // time and button
    elapsed_t = elapsed_q;
    if (smp_i.ms_tick && elapsed_q != edg_pkg::ElapsedMax) begin
      elapsed_t = elapsed_q + 8'd1;
    end
    btn_take  = (elapsed_t > debounce_ms_i) && (pressed != acc_q);
    elapsed_d = btn_take ? '0 : elapsed_t;
    acc_d     = btn_take ? pressed : acc_q;
    on_d      = on_q ^ (btn_take & pressed);

    // phase a
    a_fall    = on_q & prev_a_q & ~smp_i.enc_a;
    level_a   = level_q;
    a_armed_a = a_armed_q;
    b_armed_a = b_armed_q;
    if (a_fall) begin
      if (b_armed_q && !smp_i.enc_b) begin
        if (level_q < edg_pkg::LevelMax) begin
          level_a = level_q + 5'd1;
        end
        b_armed_a = 1'b0;
      end else begin
        a_armed_a = 1'b1;
      end
    end
    prev_a_d = smp_i.enc_a;

    // phase b
    level_d   = level_a;
    a_armed_d = a_armed_a;
    b_armed_d = b_armed_a;
    b_seen_d  = b_seen_q;
    if (on_q) begin
      if (smp_i.enc_b) begin
        b_seen_d = 1'b1;
      end else if (b_seen_q) begin
        b_seen_d = 1'b0;
        if (a_armed_a && !smp_i.enc_a) begin
          if (level_a != '0) begin
            level_d = level_a - 5'd1;
          end
          a_armed_d = 1'b0;
        end else begin
          b_armed_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_o.pwm_duty = on_d ? edg_pkg::gamma_lut(level_d) : '0;
    res_o.light_on = on_d;
    res_o.level    = level_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q      <= 1'b0;
      level_q   <= edg_pkg::LevelReset;
      acc_q     <= 1'b0;
      elapsed_q <= '0;
      a_armed_q <= 1'b0;
      b_armed_q <= 1'b0;
      b_seen_q  <= 1'b0;
      prev_a_q  <= 1'b1;
    end else if (step_i) begin
      on_q      <= on_d;
      level_q   <= level_d;
      acc_q     <= acc_d;
      elapsed_q <= elapsed_d;
      a_armed_q <= a_armed_d;
      b_armed_q <= b_armed_d;
      b_seen_q  <= b_seen_d;
      prev_a_q  <= prev_a_d;
    end
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= edg_pkg::LevelMax)
    else $error("level above maximum");

  a_toggle_on_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(on_q) |-> (elapsed_q == '0) && acc_q)
    else $error("light toggled without accepted press");

  a_level_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> $past(on_q))
    else $error("level moved while light was off");

endmodule

// ===== hdl/encoder_dimmer_with_gamma.sv =====
// Rotary encoder LED dimmer with debounced on/off button and gamma table.
// One sample transfer can be taken every clock while results are taken: a sample is held in an input
// register; when it advances it updates the dimmer state and its result is written to the output
// register in the same cycle, so a result passes the input and output registers in turn and the
// sustained rate is one sample per clock while results are taken, set by the state update in
// edg_core on each advance. While a result is not taken the input
// register still takes one more sample and then the input stalls. The
// debounce time is written over the APB port at byte address 0 (bits 7:0).
module encoder_dimmer_with_gamma (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  edg_smp_if.sink                        smp_i,
  edg_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [edg_pkg::PaddrW-1:0]     paddr,
  input  logic [edg_pkg::PdataW-1:0]     pwdata,
  output logic [edg_pkg::PdataW-1:0]     prdata,
  output logic                           pready
);

  logic                       in_valid_q, in_valid_d;
  edg_pkg::smp_t              in_data_q;
  logic                       out_valid_q, out_valid_d;
  edg_pkg::res_t              out_data_q;
  edg_pkg::res_t              core_res;
  logic                       advance;
  logic                       take;
  logic [edg_pkg::MsW-1:0]    debounce_q;
  edg_pkg::reg_idx_e          reg_idx;
  logic                       reg_hit;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = edg_pkg::reg_idx_e'(paddr[2]);
  assign reg_hit = (paddr[1:0] == 2'b00);

  always_comb begin
    prdata = '0;
    case (reg_idx)
      edg_pkg::RegDebounceMs: prdata = {{(edg_pkg::PdataW-edg_pkg::MsW){1'b0}}, debounce_q};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= edg_pkg::DebounceReset;
    end else if (psel && penable && pwrite && reg_hit
                 && reg_idx == edg_pkg::RegDebounceMs) begin
      debounce_q <= pwdata[edg_pkg::MsW-1:0];
    end
  end

  // two-stage pipeline
  assign advance       = in_valid_q && (!out_valid_q || res_o.ready);
  assign smp_i.ready   = !in_valid_q || advance;
  assign take          = smp_i.valid && smp_i.ready;

  always_comb begin
    in_valid_d  = take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_data_q.button_n <= smp_i.button_n;
      in_data_q.enc_a    <= smp_i.enc_a;
      in_data_q.enc_b    <= smp_i.enc_b;
      in_data_q.ms_tick  <= smp_i.ms_tick;
    end
    if (advance) begin
      out_data_q <= core_res;
    end
  end

  edg_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .smp_i         (in_data_q),
    .debounce_ms_i (debounce_q),
    .res_o         (core_res)
  );

  assign res_o.valid    = out_valid_q;
  assign res_o.pwm_duty = out_data_q.pwm_duty;
  assign res_o.light_on = out_data_q.light_on;
  assign res_o.level    = out_data_q.level;

endmodule

// ===== test/edg_checker.sv =====
// encoder dimmer checker: predicts results from sample transfers, compares; checks readback
module edg_checker
  import edg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  edg_smp_if                smp_i,
  edg_res_if                res_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  input  logic [PdataW-1:0] prdata,
  input  logic              pready,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] DutyTab [24] = '{
    8'd2, 8'd4, 8'd7, 8'd10, 8'd13, 8'd17, 8'd22, 8'd27, 8'd33, 8'd39, 8'd47, 8'd55,
    8'd64, 8'd74, 8'd85, 8'd97, 8'd110, 8'd124, 8'd140, 8'd158, 8'd176, 8'd196,
    8'd218, 8'd255
  };
  localparam logic [4:0] TopLevel      = 5'd23;
  localparam logic [4:0] StartLevel    = 5'd10;
  localparam logic [7:0] StartDebounce = 8'd50;
  localparam logic [7:0] MsCeil        = 8'd255;
  localparam logic [PaddrW-1:0] DebounceAddr = PaddrW'(4 * int'(RegDebounceMs));

  logic [7:0]  debounce_q;
  logic [7:0]  elapsed_q;
  logic [4:0]  level_q;
  logic        on_q;
  logic        btn_q;
  logic        a_arm_q;
  logic        b_arm_q;
  logic        b_high_q;
  logic        prev_a_q;
  res_t        expected_q [$];
  int unsigned fails = 0;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic res_t dimmer_step(input logic bn, input logic a, input logic b,
                                       input logic tick);
    logic pressed;
    logic was_on;
    res_t r;
    pressed = ~bn;
    was_on  = on_q;
    if (tick && elapsed_q != MsCeil) elapsed_q++;
    if (elapsed_q > debounce_q && pressed != btn_q) begin
      btn_q     = pressed;
      elapsed_q = '0;
      if (pressed) on_q = ~on_q;
    end
    if (was_on && prev_a_q && !a) begin
      if (b_arm_q && !b) begin
        if (level_q < TopLevel) level_q++;
        b_arm_q = 1'b0;
      end else begin
        a_arm_q = 1'b1;
      end
    end
    prev_a_q = a;
    if (was_on) begin
      if (b) begin
        b_high_q = 1'b1;
      end else if (b_high_q) begin
        b_high_q = 1'b0;
        if (a_arm_q && !a) begin
          if (level_q != '0) level_q--;
          a_arm_q = 1'b0;
        end else begin
          b_arm_q = 1'b1;
        end
      end
    end
    r.pwm_duty = on_q ? DutyTab[(level_q > TopLevel) ? TopLevel : level_q] : '0;
    r.light_on = on_q;
    r.level    = level_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      debounce_q = StartDebounce;
      elapsed_q  = '0;
      level_q    = StartLevel;
      on_q       = 1'b0;
      btn_q      = 1'b0;
      a_arm_q    = 1'b0;
      b_arm_q    = 1'b0;
      b_high_q   = 1'b0;
      prev_a_q   = 1'b1;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      if (psel && penable && pwrite && pready && paddr == DebounceAddr) begin
        debounce_q = pwdata[7:0];
      end
      if (psel && penable && !pwrite && pready && paddr == DebounceAddr &&
          prdata[7:0] != debounce_q) begin
        report_mismatch($sformatf("debounce readback got %0d expected %0d",
                                  prdata[7:0], debounce_q));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no sample waiting for it");
        end else begin
          want = expected_q.pop_front();
          if (res_i.pwm_duty != want.pwm_duty)
            report_mismatch($sformatf("pwm_duty got %0d expected %0d",
                                      res_i.pwm_duty, want.pwm_duty));
          if (res_i.light_on != want.light_on)
            report_mismatch($sformatf("light_on got %0b expected %0b",
                                      res_i.light_on, want.light_on));
          if (res_i.level != want.level)
            report_mismatch($sformatf("level got %0d expected %0d",
                                      res_i.level, want.level));
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        expected_q.push_back(dimmer_step(smp_i.button_n, smp_i.enc_a, smp_i.enc_b,
                                         smp_i.ms_tick));
      end
      pending_o    <= expected_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== test/tb_encoder_dimmer_with_gamma.sv =====
// testbench top for the encoder dimmer: clock, reset, sample and apb stimulus, verdict
module tb_encoder_dimmer_with_gamma;
  import edg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [PaddrW-1:0] DebounceAddr = PaddrW'(4 * int'(RegDebounceMs));

  // encoder phase pairs {a, b} for one detent
  localparam logic [1:0] UpSeq   [4] = '{2'b10, 2'b00, 2'b10, 2'b11};
  localparam logic [1:0] DownSeq [4] = '{2'b01, 2'b00, 2'b10, 2'b11};

  // {button_n, enc_a, enc_b, ms_tick}
  localparam logic [3:0] DirectedSmp [22] = '{
    4'b1111, 4'b1010, 4'b1110, 4'b0111, 4'b0110, 4'b1110, 4'b1111, 4'b1100,
    4'b1000, 4'b1100, 4'b1110, 4'b1010, 4'b1000, 4'b1100, 4'b1110, 4'b1111,
    4'b0011, 4'b0000, 4'b0101, 4'b1111, 4'b0001, 4'b0100
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;
  logic              calm = 1'b0;
  logic              rot_up = 1'b1;
  logic              cur_bn = 1'b1;
  int unsigned       stall_left = 0;
  int unsigned       cycles = 0;
  int unsigned       samples_sent = 0;
  int unsigned       settings_used = 0;
  int unsigned       fail_count;
  int unsigned       pending;

  edg_smp_if smp_ch ();
  edg_res_if res_ch ();

  encoder_dimmer_with_gamma dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .smp_i   (smp_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  edg_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (smp_ch),
    .res_i        (res_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5ns clk = ~clk;

  function automatic int unsigned gap_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
  endfunction

  always @(posedge clk) begin
    if (calm || stall_left == 0) begin
      res_ch.ready <= 1'b1;
      if (!calm && $urandom_range(99) < 20) stall_left <= gap_len();
    end else begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic bn, input logic a, input logic b, input logic tick);
    int unsigned gap;
    gap = (calm || $urandom_range(99) < 60) ? 0 : gap_len();
    if (gap != 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid    <= 1'b1;
    smp_ch.button_n <= bn;
    smp_ch.enc_a    <= a;
    smp_ch.enc_b    <= b;
    smp_ch.ms_tick  <= tick;
    @(posedge clk);
    while (!smp_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic apb_access(input logic write, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= DebounceAddr;
    pwdata  <= PdataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    smp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [7:0] value);
    wait_idle();
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
    settings_used++;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned tick_pct);
    int unsigned stop;
    int unsigned pick;
    int unsigned reps;
    logic [1:0]  pair;
    stop = samples_sent + count;
    while (samples_sent < stop) begin
      if ($urandom_range(19) == 0) calm <= ~calm;
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(9) == 0) rot_up = ~rot_up;
        for (int i = 0; i < 4; i++) begin
          pair = rot_up ? UpSeq[i] : DownSeq[i];
          reps = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1;
          repeat (reps) send_sample(cur_bn, pair[1], pair[0], $urandom_range(99) < tick_pct);
        end
      end else if (pick < 88) begin
        // bouncing button before it settles at its new level
        cur_bn = ~cur_bn;
        repeat ($urandom_range(4)) begin
          send_sample(1'($urandom_range(1)), 1'b1, 1'b1, $urandom_range(99) < tick_pct);
        end
        send_sample(cur_bn, 1'b1, 1'b1, $urandom_range(99) < tick_pct);
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
      end
    end
  endtask

  initial begin
    smp_ch.valid    = 1'b0;
    smp_ch.button_n = 1'b1;
    smp_ch.enc_a    = 1'b1;
    smp_ch.enc_b    = 1'b1;
    smp_ch.ms_tick  = 1'b0;
    res_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(1'b0, '0);
    set_debounce(8'd0);
    foreach (DirectedSmp[k]) begin
      send_sample(DirectedSmp[k][3], DirectedSmp[k][2], DirectedSmp[k][1], DirectedSmp[k][0]);
    end
    run_phase(350, 30);
    set_debounce(8'd1);
    run_phase(200, 50);
    set_debounce(8'd3);
    run_phase(150, 60);
    set_debounce(8'd50);
    run_phase(150, 80);
    set_debounce(8'd254);
    run_phase(300, 95);
    set_debounce(8'd255);
    run_phase(100, 90);
    wait_idle();
    $display("%0d sample transfers over %0d debounce settings from 0 to 255,", samples_sent,
             settings_used);
    $display("detent turns both ways, button bounce and noise, stalls on both channels");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
